// ===== rtl/krtbq_pkg.sv =====
// Package for the keyed record table with box query.
// Holds the table size, request and status codes, controller states and
// the command/status structs shared by the controller and the datapath.
package krtbq_pkg;

  localparam int Capacity = 64;
  localparam int IdxW     = $clog2(Capacity);
  localparam int CntW     = $clog2(Capacity + 1);

  localparam logic signed [7:0] LatMax = 8'sd90;
  localparam logic signed [7:0] LatMin = -8'sd90;
  localparam logic signed [8:0] LonMax = 9'sd180;
  localparam logic signed [8:0] LonMin = -9'sd180;

  typedef enum logic [2:0] {
    REQ_INSERT    = 3'd0,
    REQ_DEL_NAME  = 3'd1,
    REQ_DEL_COORD = 3'd2,
    REQ_BOX       = 3'd3,
    REQ_FIND_NAME = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    ST_ADDED        = 3'd0,
    ST_NAME_EXISTS  = 3'd1,
    ST_COORDS_EXIST = 3'd2,
    ST_BAD_COORDS   = 3'd3,
    ST_DELETED      = 3'd4,
    ST_NOT_FOUND    = 3'd5,
    ST_MATCH        = 3'd6,
    ST_FULL         = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_WRITE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FETCH,
    S_EMIT,
    S_EMIT_BOX
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic            load_req;   // capture request beat
    logic            rd_en;      // read entry at rd_addr
    logic [IdxW-1:0] rd_addr;
    logic            wr_req;     // write request record at count
    logic            wr_shift;   // write last read entry at wr_addr
    logic [IdxW-1:0] wr_addr;
    logic            cnt_inc;
    logic            cnt_dec;
    logic            load_out;   // load output register from read data
    logic            out_rec;    // output carries the record
    status_t         out_status;
    logic [IdxW-1:0] out_slot;
    logic            out_last;
  } krtbq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    req_t            req;
    logic            coord_bad;  // insert coords out of range
    logic            box_bad;
    logic            name_eq;    // read entry matches name
    logic            coord_eq;
    logic            in_box;
    logic [CntW-1:0] count;
    logic            out_busy;   // output register holds an unsent beat
  } krtbq_sts_t;

endpackage

// ===== rtl/krtbq_datapath.sv =====
// Datapath: request registers, record memories, compare logic, count and
// the output register. Depends on krtbq_pkg.
module krtbq_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  krtbq_pkg::krtbq_cmd_t        cmd,
  output krtbq_pkg::krtbq_sts_t        sts,
  input  logic [2:0]                   req_type,
  input  logic [63:0]                  name_word0,
  input  logic [63:0]                  name_word1,
  input  logic [63:0]                  name_word2,
  input  logic signed [7:0]            lat_a,
  input  logic signed [7:0]            lat_b,
  input  logic signed [8:0]            lon_a,
  input  logic signed [8:0]            lon_b,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [2:0]                   status,
  output logic [5:0]                   slot,
  output logic [63:0]                  out_name0,
  output logic [63:0]                  out_name1,
  output logic [63:0]                  out_name2,
  output logic signed [7:0]            out_lat,
  output logic signed [8:0]            out_lon,
  output logic                         last
);
  import krtbq_pkg::*;

  logic [63:0] mem_n0 [Capacity];
  logic [63:0] mem_n1 [Capacity];
  logic [63:0] mem_n2 [Capacity];
  logic [7:0]  mem_lat [Capacity];
  logic [8:0]  mem_lon [Capacity];

  logic [2:0]         rq;
  logic [63:0]        rn0, rn1, rn2;
  logic signed [7:0]  rlat, x1, x2;
  logic signed [8:0]  rlon, y1, y2;
  logic [63:0]        d0, d1, d2;
  logic signed [7:0]  dlat;
  logic signed [8:0]  dlon;
  logic [CntW-1:0]    count;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      rq   <= req_type;
      rn0  <= name_word0;
      rn1  <= name_word1;
      rn2  <= name_word2;
      rlat <= lat_a;
      rlon <= lon_a;
      x1   <= (lat_a < lat_b) ? lat_a : lat_b;
      x2   <= (lat_a < lat_b) ? lat_b : lat_a;
      y1   <= (lon_a < lon_b) ? lon_a : lon_b;
      y2   <= (lon_a < lon_b) ? lon_b : lon_a;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      d0   <= mem_n0[cmd.rd_addr];
      d1   <= mem_n1[cmd.rd_addr];
      d2   <= mem_n2[cmd.rd_addr];
      dlat <= mem_lat[cmd.rd_addr];
      dlon <= mem_lon[cmd.rd_addr];
    end
    if (cmd.wr_req) begin
      mem_n0[count[IdxW-1:0]]  <= rn0;
      mem_n1[count[IdxW-1:0]]  <= rn1;
      mem_n2[count[IdxW-1:0]]  <= rn2;
      mem_lat[count[IdxW-1:0]] <= rlat;
      mem_lon[count[IdxW-1:0]] <= rlon;
    end else if (cmd.wr_shift) begin
      mem_n0[cmd.wr_addr]  <= d0;
      mem_n1[cmd.wr_addr]  <= d1;
      mem_n2[cmd.wr_addr]  <= d2;
      mem_lat[cmd.wr_addr] <= dlat;
      mem_lon[cmd.wr_addr] <= dlon;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CntW'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // record fields come from the last memory read, or the new record on add; they are zero when no record is carried
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status <= cmd.out_status;
      slot   <= 6'(cmd.out_slot);
      last   <= cmd.out_last;
      if (!cmd.out_rec) begin
        out_name0 <= '0; out_name1 <= '0; out_name2 <= '0;
        out_lat   <= '0; out_lon   <= '0;
      end else if (cmd.out_status == ST_ADDED) begin
        out_name0 <= rn0; out_name1 <= rn1; out_name2 <= rn2;
        out_lat   <= rlat; out_lon  <= rlon;
      end else begin
        out_name0 <= d0; out_name1 <= d1; out_name2 <= d2;
        out_lat   <= dlat; out_lon  <= dlon;
      end
    end
  end

  always_comb begin
    sts.req       = req_t'(rq);
    sts.coord_bad = (rlat > LatMax) || (rlat < LatMin) || (rlon > LonMax) || (rlon < LonMin);
    sts.box_bad   = (x1 < LatMin) || (x2 > LatMax) || (y1 < LonMin) || (y2 > LonMax);
    sts.name_eq   = (d0 == rn0) && (d1 == rn1) && (d2 == rn2);
    sts.coord_eq  = (dlat == rlat) && (dlon == rlon);
    sts.in_box    = (dlat >= x1) && (dlat <= x2) && (dlon >= y1) && (dlon <= y2);
    sts.count     = count;
    sts.out_busy  = out_valid && !out_ready;
  end

endmodule

// ===== rtl/krtbq_ctrl.sv =====
// Controller: sequences the scan, insert, shift and result beats.
// Depends on krtbq_pkg.
module krtbq_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  krtbq_pkg::krtbq_sts_t sts,
  output krtbq_pkg::krtbq_cmd_t cmd
);
  import krtbq_pkg::*;

  state_t          state, state_next;
  logic [CntW-1:0] idx, idx_next;
  logic [IdxW-1:0] hit, hit_next;
  logic            found, found_next;   // box: a match is held at hit
  logic            blast, blast_next;   // box: held match is the final beat
  logic            nm, nm_next;         // insert: cleared per request; a name clash goes straight to fetch
  logic            cm, cm_next;         // insert: first coord clash seen
  logic [IdxW-1:0] cpos, cpos_next;
  status_t         pst, pst_next;       // pending status for emit
  logic            prec, prec_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0; hit <= '0; found <= 1'b0; blast <= 1'b0; nm <= 1'b0; cm <= 1'b0;
      cpos <= '0; pst <= ST_ADDED; prec <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next; hit <= hit_next; found <= found_next; blast <= blast_next;
      nm <= nm_next;
      cm <= cm_next; cpos <= cpos_next; pst <= pst_next; prec <= prec_next;
    end
  end

  logic [IdxW-1:0] cur;
  logic            at_end;
  logic            scan_hit;

  always_comb begin
    cur    = idx[IdxW-1:0];
    at_end = (idx + CntW'(1)) >= sts.count;
    case (sts.req)
      REQ_DEL_COORD: scan_hit = sts.coord_eq;
      default:       scan_hit = sts.name_eq;
    endcase
  end

  always_comb begin
    state_next = state;
    idx_next = idx; hit_next = hit; found_next = found; blast_next = blast; nm_next = nm;
    cm_next = cm; cpos_next = cpos; pst_next = pst; prec_next = prec;
    in_ready = 1'b0;
    cmd = '0;
    cmd.out_status = pst;
    cmd.out_slot   = hit;
    cmd.out_rec    = prec;
    cmd.out_last   = 1'b1;
    cmd.rd_addr    = cur;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          idx_next = '0; found_next = 1'b0; nm_next = 1'b0; cm_next = 1'b0;
          state_next = S_CHECK;
        end
      end
      // decide on the captured request; first read issued here when the table is not empty and the bounds are good
      S_CHECK: begin
        prec_next = 1'b0;
        hit_next  = '0;
        case (sts.req)
          REQ_INSERT, REQ_BOX, REQ_DEL_NAME, REQ_DEL_COORD, REQ_FIND_NAME: begin
            if ((sts.req == REQ_INSERT && sts.coord_bad) ||
                (sts.req == REQ_BOX && sts.box_bad)) begin
              pst_next = ST_BAD_COORDS;
              state_next = S_EMIT;
            end else if (sts.count == '0) begin
              if (sts.req == REQ_INSERT) begin
                state_next = S_WRITE;
              end else begin
                pst_next = ST_NOT_FOUND;
                state_next = S_EMIT;
              end
            end else begin
              cmd.rd_en = 1'b1;
              state_next = S_READ;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      // data of entry idx is valid; issue next read when continuing
      S_READ: begin
        case (sts.req)
          REQ_INSERT: begin
            if (sts.name_eq) begin
              hit_next = cur; pst_next = ST_NAME_EXISTS; prec_next = 1'b1;
              state_next = S_FETCH;
            end else begin
              if (sts.coord_eq && !cm) begin
                cm_next = 1'b1; cpos_next = cur;
              end
              if (at_end) begin
                if (cm || sts.coord_eq) begin
                  hit_next = cm ? cpos : cur;
                  pst_next = ST_COORDS_EXIST; prec_next = 1'b1;
                  state_next = S_FETCH;
                end else begin
                  state_next = S_WRITE;
                end
              end else begin
                idx_next = idx + CntW'(1);
                cmd.rd_addr = IdxW'(idx + CntW'(1));
                cmd.rd_en = 1'b1;
              end
            end
          end
          REQ_BOX: begin
            if (sts.in_box && found) begin
              // a later match exists: re-read the held one and send it
              cmd.rd_en = 1'b1;
              cmd.rd_addr = hit;
              blast_next = 1'b0;
              state_next = S_EMIT_BOX;
            end else if (sts.in_box) begin
              hit_next = cur;
              found_next = 1'b1;
              if (at_end) begin
                blast_next = 1'b1;
                state_next = S_EMIT_BOX;
              end else begin
                idx_next = idx + CntW'(1);
                cmd.rd_addr = IdxW'(idx + CntW'(1));
                cmd.rd_en = 1'b1;
              end
            end else if (at_end) begin
              if (found) begin
                cmd.rd_en = 1'b1;
                cmd.rd_addr = hit;
                blast_next = 1'b1;
                state_next = S_EMIT_BOX;
              end else begin
                pst_next = ST_NOT_FOUND; state_next = S_EMIT;
              end
            end else begin
              idx_next = idx + CntW'(1);
              cmd.rd_addr = IdxW'(idx + CntW'(1));
              cmd.rd_en = 1'b1;
            end
          end
          default: begin
            if (scan_hit) begin
              hit_next = cur; prec_next = 1'b1;
              if (sts.req == REQ_FIND_NAME) begin
                pst_next = ST_MATCH; state_next = S_EMIT;
              end else begin
                pst_next = ST_DELETED; state_next = S_EMIT;
              end
            end else if (at_end) begin
              pst_next = ST_NOT_FOUND; state_next = S_EMIT;
            end else begin
              idx_next = idx + CntW'(1);
              cmd.rd_addr = IdxW'(idx + CntW'(1));
              cmd.rd_en = 1'b1;
            end
          end
        endcase
      end
      S_WRITE: begin
        if (sts.count >= CntW'(Capacity)) begin
          pst_next = ST_FULL; prec_next = 1'b0; hit_next = '0;
          state_next = S_EMIT;
        end else begin
          cmd.wr_req = 1'b1;
          cmd.cnt_inc = 1'b1;
          hit_next = sts.count[IdxW-1:0];
          pst_next = ST_ADDED; prec_next = 1'b1;
          state_next = S_EMIT;
        end
      end
      // re-read the clash entry so the output carries it
      S_FETCH: begin
        cmd.rd_en = 1'b1;
        cmd.rd_addr = hit;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          cmd.out_rec  = prec;
          if (pst == ST_DELETED) begin
            idx_next = {1'b0, hit};
            state_next = S_SHIFT_RD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      // send the held box match; unless it is the final beat, the match at idx becomes the held one
      S_EMIT_BOX: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          cmd.out_status = ST_MATCH; cmd.out_rec = 1'b1; cmd.out_last = blast;
          if (blast) begin
            state_next = S_IDLE;
          end else begin
            hit_next = cur;
            if (at_end) begin
              // last entry matched: fetch it and close with it
              cmd.rd_en = 1'b1;
              cmd.rd_addr = cur;
              blast_next = 1'b1;
            end else begin
              idx_next = idx + CntW'(1);
              cmd.rd_addr = IdxW'(idx + CntW'(1));
              cmd.rd_en = 1'b1;
              state_next = S_READ;
            end
          end
        end
      end
      // shift later entries down one place, then decrement the count
      S_SHIFT_RD: begin
        if (at_end) begin
          cmd.cnt_dec = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_addr = IdxW'(idx + CntW'(1));
          state_next = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.wr_addr = cur;
        idx_next = idx + CntW'(1);
        state_next = S_SHIFT_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/keyed_record_table_box_query.sv =====
// Keyed record table with box query: top level.
// Each request scans the stored entries in order; a delete then shifts
// the later entries down one place. One request at a time; a box find holds
// each match until the next one or the scan end, then sends it as a beat.
// Reset (rst, synchronous) empties the table; stores need no clearing.
module keyed_record_table_box_query (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         req_type,
  input  logic [63:0]        name_word0,
  input  logic [63:0]        name_word1,
  input  logic [63:0]        name_word2,
  input  logic signed [7:0]  lat_a,
  input  logic signed [7:0]  lat_b,
  input  logic signed [8:0]  lon_a,
  input  logic signed [8:0]  lon_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic [5:0]         slot,
  output logic [63:0]        out_name0,
  output logic [63:0]        out_name1,
  output logic [63:0]        out_name2,
  output logic signed [7:0]  out_lat,
  output logic signed [8:0]  out_lon,
  output logic               last
);
  import krtbq_pkg::*;

  krtbq_cmd_t cmd;
  krtbq_sts_t sts;

  krtbq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  krtbq_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .req_type(req_type), .name_word0(name_word0), .name_word1(name_word1),
    .name_word2(name_word2), .lat_a(lat_a), .lat_b(lat_b),
    .lon_a(lon_a), .lon_b(lon_b),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .slot(slot), .out_name0(out_name0), .out_name1(out_name1),
    .out_name2(out_name2), .out_lat(out_lat), .out_lon(out_lon), .last(last)
  );

endmodule

// ===== test/keyed_record_table_box_query_test.sv =====
// Testbench for keyed_record_table_box_query: random and directed requests
// checked beat by beat against a behavioral table kept here.
// Depends on krtbq_pkg for request and status codes.
`timescale 1ns / 1ps

module keyed_record_table_box_query_test;
  import krtbq_pkg::*;

  typedef struct packed {
    logic [2:0]         status;
    logic [5:0]         slot;
    logic [63:0]        n0, n1, n2;
    logic signed [7:0]  lat;
    logic signed [8:0]  lon;
    logic               last;
  } rec_beat_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [2:0] req_type = 0;
  logic [63:0] name_word0 = 0, name_word1 = 0, name_word2 = 0;
  logic signed [7:0] lat_a = 0, lat_b = 0;
  logic signed [8:0] lon_a = 0, lon_b = 0;
  logic [2:0] status;
  logic [5:0] slot;
  logic [63:0] out_name0, out_name1, out_name2;
  logic signed [7:0] out_lat;
  logic signed [8:0] out_lon;
  logic last;

  keyed_record_table_box_query dut (.*);

  initial forever #10 clk = ~clk;

  // table mirror
  logic [63:0] tbl_n0 [Capacity], tbl_n1 [Capacity], tbl_n2 [Capacity];
  int tbl_lat [Capacity], tbl_lon [Capacity];
  int tbl_count = 0;
  rec_beat_t pending_beats [$];
  int errors = 0, idle_cycles = 0;
  bit calm = 0;
  // names used so far, to draw clashing requests
  logic [191:0] used_names [$];

  function automatic rec_beat_t beat_of(status_t st, int p, bit lst);
    rec_beat_t b;
    b = '0;
    b.status = st;
    b.last = lst;
    if (p >= 0) begin
      b.slot = 6'(p);
      b.n0 = tbl_n0[p]; b.n1 = tbl_n1[p]; b.n2 = tbl_n2[p];
      b.lat = 8'(tbl_lat[p]); b.lon = 9'(tbl_lon[p]);
    end
    return b;
  endfunction

  function automatic int lookup_name(logic [63:0] a, b, c);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_n0[i] == a && tbl_n1[i] == b && tbl_n2[i] == c) return i;
    return -1;
  endfunction

  function automatic int lookup_coords(int la, int lo);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_lat[i] == la && tbl_lon[i] == lo) return i;
    return -1;
  endfunction

  function automatic bit lat_in(int v); return v >= -90 && v <= 90; endfunction
  function automatic bit lon_in(int v); return v >= -180 && v <= 180; endfunction

  task automatic predict_request(logic [2:0] rq, logic [63:0] a, b, c,
                                 int la, int lb, int oa, int ob);
    int p, pc, x1, x2, y1, y2, n;
    case (rq)
      REQ_INSERT: begin
        p = lookup_name(a, b, c);
        pc = lookup_coords(la, oa);
        if (!lat_in(la) || !lon_in(oa)) pending_beats.push_back(beat_of(ST_BAD_COORDS, -1, 1));
        else if (p >= 0)
          pending_beats.push_back(beat_of(ST_NAME_EXISTS, p, 1));
        else if (pc >= 0)
          pending_beats.push_back(beat_of(ST_COORDS_EXIST, pc, 1));
        else if (tbl_count >= Capacity) pending_beats.push_back(beat_of(ST_FULL, -1, 1));
        else begin
          p = tbl_count;
          tbl_n0[p] = a; tbl_n1[p] = b; tbl_n2[p] = c;
          tbl_lat[p] = la; tbl_lon[p] = oa;
          tbl_count++;
          pending_beats.push_back(beat_of(ST_ADDED, p, 1));
        end
      end
      REQ_DEL_NAME, REQ_DEL_COORD: begin
        p = (rq == REQ_DEL_NAME) ? lookup_name(a, b, c) : lookup_coords(la, oa);
        if (p < 0) pending_beats.push_back(beat_of(ST_NOT_FOUND, -1, 1));
        else begin
          pending_beats.push_back(beat_of(ST_DELETED, p, 1));
          for (int i = p; i + 1 < tbl_count; i++) begin
            tbl_n0[i] = tbl_n0[i+1]; tbl_n1[i] = tbl_n1[i+1]; tbl_n2[i] = tbl_n2[i+1];
            tbl_lat[i] = tbl_lat[i+1]; tbl_lon[i] = tbl_lon[i+1];
          end
          tbl_count--;
        end
      end
      REQ_BOX: begin
        x1 = la < lb ? la : lb; x2 = la < lb ? lb : la;
        y1 = oa < ob ? oa : ob; y2 = oa < ob ? ob : oa;
        n = 0;
        if (!lat_in(x1) || !lat_in(x2) || !lon_in(y1) || !lon_in(y2))
          pending_beats.push_back(beat_of(ST_BAD_COORDS, -1, 1));
        else begin
          for (int i = 0; i < tbl_count; i++)
            if (tbl_lat[i] >= x1 && tbl_lat[i] <= x2 && tbl_lon[i] >= y1 && tbl_lon[i] <= y2) begin
              pending_beats.push_back(beat_of(ST_MATCH, i, 0));
              n++;
            end
          if (n == 0) pending_beats.push_back(beat_of(ST_NOT_FOUND, -1, 1));
          else pending_beats[$].last = 1;
        end
      end
      REQ_FIND_NAME: begin
        p = lookup_name(a, b, c);
        pending_beats.push_back(p < 0 ? beat_of(ST_NOT_FOUND, -1, 1) : beat_of(ST_MATCH, p, 1));
      end
      default: ;
    endcase
  endtask

  task automatic send_request(logic [2:0] rq, logic [63:0] a, b, c,
                              int la, int lb, int oa, int ob);
    if (!calm && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 7)) @(negedge clk);
    in_valid = 1; req_type = rq;
    name_word0 = a; name_word1 = b; name_word2 = c;
    lat_a = 8'(la); lat_b = 8'(lb); lon_a = 9'(oa); lon_b = 9'(ob);
    do @(posedge clk); while (!in_ready);
    predict_request(rq, a, b, c, la, lb, oa, ob);
    if (rq == REQ_INSERT) used_names.push_back({a, b, c});
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain_results();
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (2 * Capacity + 10) @(negedge clk);
  endtask

  // result checker and output stall
  always @(posedge clk) begin
    rec_beat_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = {status, slot, out_name0, out_name1, out_name2, out_lat, out_lon, last};
      if (pending_beats.size() == 0) begin
        $display("%0t unexpected beat %h", $time, got);
        errors++;
      end else begin
        want = pending_beats.pop_front();
        if (got !== want)
          $display("%0t mismatch: expected st=%0d slot=%0d n=%h/%h/%h lat=%0d lon=%0d last=%0b got st=%0d slot=%0d n=%h/%h/%h lat=%0d lon=%0d last=%0b",
                   $time, want.status, want.slot, want.n0, want.n1, want.n2, want.lat,
                   want.lon, want.last, got.status, got.slot, got.n0, got.n1, got.n2,
                   got.lat, got.lon, got.last);
        if (got !== want) errors++;
      end
    end
  end

  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 0; stall--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 0; stall = $urandom_range(0, 6);
      end else out_ready <= 1;
    end
  end

  // watchdog: cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 4000) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    logic [63:0] ones;
    ones = '1;
    send_request(REQ_FIND_NAME, 1, 0, 0, 0, 0, 0, 0);   // empty table
    send_request(REQ_DEL_NAME, 1, 0, 0, 0, 0, 0, 0);
    send_request(REQ_DEL_COORD, 0, 0, 0, 0, 0, 0, 0);
    send_request(REQ_BOX, 0, 0, 0, -90, 90, -180, 180);
    send_request(REQ_INSERT, ones, ones, ones, 90, 0, 180, 0);
    send_request(REQ_INSERT, 0, 0, 0, -90, 0, -180, 0);
    send_request(REQ_INSERT, 64'h41, 0, 0, 91, 0, 0, 0);
    send_request(REQ_INSERT, 64'h41, 0, 0, -128, 0, -256, 0);
    send_request(REQ_INSERT, 64'h41, 0, 0, 0, 0, 255, 0);
    send_request(REQ_INSERT, 64'h41, 0, 0, 0, 0, -181, 0);
    send_request(REQ_INSERT, 0, 0, 0, 5, 0, 5, 0);         // name exists
    send_request(REQ_INSERT, 64'h42, 0, 0, 90, 0, 180, 0); // coords exist
    send_request(REQ_INSERT, 64'h0042, 64'h0100, 0, 10, 0, 20, 0); // byte after zero
    send_request(REQ_BOX, 0, 0, 0, 127, -128, 255, -256);  // bad bounds
    send_request(REQ_BOX, 0, 0, 0, 90, -90, 180, -180);    // swapped, all match
    send_request(REQ_BOX, 0, 0, 0, 50, 60, 50, 60);        // none
    send_request(REQ_FIND_NAME, ones, ones, ones, 0, 0, 0, 0);
    send_request(3'd5, 0, 0, 0, 0, 0, 0, 0);
    send_request(3'd6, 0, 0, 0, 0, 0, 0, 0);
    send_request(3'd7, 0, 0, 0, 0, 0, 0, 0);
    send_request(REQ_DEL_COORD, 0, 0, 0, -90, 0, -180, 0);
    send_request(REQ_DEL_NAME, ones, ones, ones, 0, 0, 0, 0);
    drain_results();
  endtask

  task automatic test_fill_table();
    // fill to capacity, hit full, query all, then delete the last entry by coords and the first by name
    for (int i = 0; tbl_count < Capacity && i < 200; i++)
      send_request(REQ_INSERT, rnd64(), rnd64(), 64'(i), $urandom_range(0, 180) - 90, 0,
                   $urandom_range(0, 360) - 180, 0);
    send_request(REQ_INSERT, 64'h77, 0, 0, 1, 0, 1, 0);
    send_request(REQ_BOX, 0, 0, 0, -90, 90, -180, 180);
    send_request(REQ_DEL_COORD, 0, 0, 0, tbl_lat[Capacity-1], 0, tbl_lon[Capacity-1], 0);
    send_request(REQ_DEL_NAME, tbl_n0[0], tbl_n1[0], tbl_n2[0], 0, 0, 0, 0);
    drain_results();
  endtask

  task automatic test_random(int n);
    logic [191:0] nm;
    logic [2:0] rq;
    int sel;
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) drain_results();   // pause until every result is back
      if (k == 3 * n / 4) calm = 1;
      sel = $urandom_range(0, 9);
      nm = {rnd64(), rnd64(), rnd64()};
      if ($urandom_range(0, 1) && used_names.size() > 0)
        nm = used_names[$urandom_range(0, used_names.size() - 1)];
      else if ($urandom_range(0, 2) != 0) nm = {rnd64() & 64'h00ff_ffff, 128'b0};
      rq = sel < 4 ? REQ_INSERT : sel < 5 ? REQ_DEL_NAME : sel < 6 ? REQ_DEL_COORD :
           sel < 8 ? REQ_BOX : sel < 9 ? REQ_FIND_NAME : 3'($urandom_range(0, 7));
      if ($urandom_range(0, 7) == 0)
        send_request(rq, nm[191:128], nm[127:64], nm[63:0], $urandom_range(0, 255) - 128,
                     $urandom_range(0, 255) - 128, $urandom_range(0, 511) - 256,
                     $urandom_range(0, 511) - 256);
      else if ((rq == REQ_DEL_COORD || rq == REQ_INSERT) && tbl_count > 0 &&
               $urandom_range(0, 2) == 0) begin
        sel = $urandom_range(0, tbl_count - 1);
        send_request(rq, nm[191:128], nm[127:64], nm[63:0], tbl_lat[sel], 0, tbl_lon[sel], 0);
      end else
        send_request(rq, nm[191:128], nm[127:64], nm[63:0], $urandom_range(0, 20) - 10,
                     $urandom_range(0, 180) - 90, $urandom_range(0, 20) - 10,
                     $urandom_range(0, 360) - 180);
    end
    drain_results();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_directed();
    test_fill_table();
    test_random(30);
    if (errors == 0 && pending_beats.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
